// ----- sv/dpsg_pkg.sv -----
package dpsg_pkg;

	localparam int unsigned NUM_CHIPS_DEF = 2;
	localparam int unsigned HOLD_LOAD_DEF = 6;

	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned VOL_W    = 4;
	localparam int unsigned HOLD_W   = 4;
	localparam int unsigned OHOLD_W  = 3;
	localparam int unsigned CH_W     = 2;
	localparam int unsigned CH_PER_CHIP = 4;

	localparam logic [CH_W-1:0]  CH_NOISE   = 2'd3;
	localparam logic [VOL_W-1:0] VOL_SILENT = 4'hF;

	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 32;

	typedef enum logic {
		KIND_PERIOD = 1'b0,
		KIND_VOLUME = 1'b1
	} kind_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [VOL_W-1:0]    volume;
		logic [VOL_W-1:0]    min_volume;
		logic [HOLD_W-1:0]   hold;
	} chan_t;

	localparam chan_t CHAN_RESET = '{
		period:     '0,
		volume:     VOL_SILENT,
		min_volume: VOL_SILENT,
		hold:       '0
	};

	typedef struct packed {
		logic [CH_W-1:0] ch;
		kind_t           kind;
	} latch_t;

endpackage

// ----- sv/dual_psg_register_write.sv -----
// Channel      | Dir | tdata                          | tuser
// s_axis       | in  | write_byte                     | chip_sel
// m_axis       | out | see port comment               | out_chip
//
// One word per cycle unless stalled; words pass stage 1, then the output register.
// Channel state lives in a one-port-read/one-port-write RAM with registered
// read; a write to the entry being read in the same cycle is forwarded.
// Reset clears per-entry valid bits, so no clearing pass is needed.
// A stalled output holds the stage behind it; one more word is taken while
// the output waits if that stage is empty.
module dual_psg_register_write #(
	parameter int unsigned NUM_CHIPS = dpsg_pkg::NUM_CHIPS_DEF,
	parameter int unsigned HOLD_LOAD = dpsg_pkg::HOLD_LOAD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dpsg_pkg::IN_DATA_W-1:0]   s_tdata,  // [7:0] write_byte
	input  logic                             s_tuser,  // [0] chip_sel
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] out_channel, [2] out_is_volume, [12:3] out_period,
	// [16:13] out_volume, [20:17] out_min_volume, [23:21] out_hold,
	// [24] out_changed, [31:25] zero
	output logic [dpsg_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tuser   // [0] out_chip
);
	import dpsg_pkg::*;

	localparam int unsigned CHIP_W = (NUM_CHIPS > 1) ? $clog2(NUM_CHIPS) : 1;
	localparam int unsigned DEPTH  = NUM_CHIPS * CH_PER_CHIP;
	localparam int unsigned IDX_W  = CHIP_W + CH_W;
	localparam logic [HOLD_W-1:0] HOLD_VAL = HOLD_W'(HOLD_LOAD);

	// input side
	logic              accept;
	logic              advance;
	logic [CHIP_W-1:0] chip;
	latch_t            latch_q [NUM_CHIPS];
	latch_t            latch_cur;
	logic [IDX_W-1:0]  idx;

	// stage 1
	logic              valid_s1;
	logic [CHIP_W-1:0] chip_s1;
	latch_t            latch_s1;
	logic [7:0]        byte_s1;
	logic [IDX_W-1:0]  idx_s1;
	chan_t             rdata_s1;
	logic              rvalid_s1;
	logic              fwd_hit_s1;
	chan_t             fwd_s1;
	chan_t             cur_s1;
	chan_t             nxt_s1;
	logic              changed_s1;

	// output register
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic              out_chip_q;

	chan_t             mem [DEPTH];
	logic [DEPTH-1:0]  mem_valid_q;
	logic              wr_en;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = valid_s1 && advance;

	always_comb begin
		if (NUM_CHIPS > 1) begin
			chip = CHIP_W'(s_tuser);
		end else begin
			chip = '0;
		end
		if (s_tdata[7]) begin
			latch_cur.ch   = s_tdata[6:5];
			latch_cur.kind = kind_t'(s_tdata[4]);
		end else begin
			latch_cur = latch_q[chip];
		end
		idx = {chip, latch_cur.ch};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHIPS; i++) begin
				latch_q[i] <= '{ch: '0, kind: KIND_PERIOD};
			end
		end else if (accept && s_tdata[7]) begin
			latch_q[chip] <= latch_cur;
		end
	end

	// channel RAM, read-before-write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1] <= nxt_s1;
		end
		if (accept) begin
			rdata_s1 <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_valid_q <= '0;
		end else if (wr_en) begin
			mem_valid_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chip_s1    <= chip;
			latch_s1   <= latch_cur;
			byte_s1    <= s_tdata;
			idx_s1     <= idx;
			rvalid_s1  <= mem_valid_q[idx];
			fwd_hit_s1 <= wr_en && (idx_s1 == idx);
			fwd_s1     <= nxt_s1;
		end
	end

	always_comb begin
		if (fwd_hit_s1) begin
			cur_s1 = fwd_s1;
		end else if (rvalid_s1) begin
			cur_s1 = rdata_s1;
		end else begin
			cur_s1 = CHAN_RESET;
		end
		nxt_s1 = cur_s1;
		if (byte_s1[7]) begin
			if (latch_s1.kind == KIND_PERIOD) begin
				nxt_s1.period = {cur_s1.period[PERIOD_W-1:4], byte_s1[3:0]};
			end else begin
				nxt_s1.volume = byte_s1[3:0];
				if (byte_s1[3:0] < cur_s1.min_volume) begin
					nxt_s1.min_volume = byte_s1[3:0];
				end
				if (byte_s1[3:0] != VOL_SILENT) begin
					nxt_s1.hold = HOLD_VAL;
				end
			end
		end else if (latch_s1.kind == KIND_PERIOD) begin
			if (latch_s1.ch == CH_NOISE) begin
				nxt_s1.period = {7'd0, byte_s1[2:0]};
			end else begin
				nxt_s1.period = {byte_s1[5:0], cur_s1.period[3:0]};
			end
		end
		changed_s1 = (nxt_s1 != cur_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			out_chip_q <= chip_s1[0];
			out_data_q <= {7'd0, changed_s1, nxt_s1.hold[OHOLD_W-1:0],
				nxt_s1.min_volume, nxt_s1.volume, nxt_s1.period,
				latch_s1.kind, latch_s1.ch};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_chip_q;

`ifndef SYNTH
	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with stage 1 empty");

	a_latch_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tdata[7]) |=> (latch_s1.ch == $past(s_tdata[6:5])))
		else $error("latched channel not carried into stage 1");

	a_vol_data_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !byte_s1[7] && latch_s1.kind == KIND_VOLUME) |-> !changed_s1)
		else $error("data word after volume latch changed state");

	a_fwd_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && wr_en && idx_s1 == idx) |=> fwd_hit_s1)
		else $error("missed forward on same-entry access");
`endif

endmodule

// ----- dv/tb_dual_psg_register_write.sv -----
`timescale 1ns / 100ps

module tb_dual_psg_register_write;
	import dpsg_pkg::*;

	localparam int unsigned N_CHIPS     = NUM_CHIPS_DEF;
	localparam int unsigned HOLD_VALUE  = HOLD_LOAD_DEF;
	localparam int unsigned N_RANDOM    = 1700;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned HOLD_AT     = 300;
	localparam int unsigned MAX_IDLE    = 11;
	localparam int unsigned DRAIN_TICKS = 10;

	localparam logic [7:0] LATCH_BIT = 8'h80;

	typedef struct packed {
		logic                chip;
		logic [CH_W-1:0]     ch;
		kind_t               kind;
		logic [PERIOD_W-1:0] period;
		logic [VOL_W-1:0]    volume;
		logic [VOL_W-1:0]    min_volume;
		logic [OHOLD_W-1:0]  hold;
		logic                changed;
	} chan_report_t;

	class psg_scoreboard;
		latch_t       latched[N_CHIPS];
		chan_t        chans[N_CHIPS * CH_PER_CHIP];
		chan_report_t pending[$];
		int           errors;

		function new();
			foreach (latched[i]) latched[i] = '{ch: '0, kind: KIND_PERIOD};
			foreach (chans[i]) chans[i] = CHAN_RESET;
			errors = 0;
		endfunction

		// Accepted input word: update the channel copy and queue the report.
		function void note_write(logic chip, logic [7:0] wb);
			int unsigned  chip_i;
			int unsigned  idx;
			latch_t       lt;
			chan_t        prev;
			chan_t        cur;
			chan_report_t rep;
			chip_i = int'(chip) % N_CHIPS;
			if (wb[7]) begin
				lt.ch   = wb[6:5];
				lt.kind = kind_t'(wb[4]);
				latched[chip_i] = lt;
			end else begin
				lt = latched[chip_i];
			end
			idx  = chip_i * CH_PER_CHIP + lt.ch;
			prev = chans[idx];
			cur  = prev;
			if (wb[7]) begin
				if (lt.kind == KIND_PERIOD) begin
					cur.period[3:0] = wb[3:0];
				end else begin
					cur.volume = wb[3:0];
					if (wb[3:0] < cur.min_volume)
						cur.min_volume = wb[3:0];
					if (wb[3:0] != VOL_SILENT)
						cur.hold = HOLD_W'(HOLD_VALUE & 'hF);
				end
			end else if (lt.kind == KIND_PERIOD) begin
				if (lt.ch == CH_NOISE)
					cur.period = PERIOD_W'(wb[2:0]);
				else
					cur.period[9:4] = wb[5:0];
			end
			// data after a volume latch leaves the channel alone
			chans[idx] = cur;
			rep.chip       = chip_i[0];
			rep.ch         = lt.ch;
			rep.kind       = lt.kind;
			rep.period     = cur.period;
			rep.volume     = cur.volume;
			rep.min_volume = cur.min_volume;
			rep.hold       = cur.hold[OHOLD_W-1:0];
			rep.changed    = (cur != prev);
			pending.push_back(rep);
		endfunction

		function void compare_field(string name, int unsigned e, int unsigned a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data, logic chip);
			chan_report_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual tdata %h tuser %0d",
					$time, data, chip);
				errors++;
				return;
			end
			e = pending.pop_front();
			compare_field("out_chip", e.chip, chip);
			compare_field("out_channel", e.ch, data[1:0]);
			compare_field("out_is_volume", e.kind, data[2]);
			compare_field("out_period", e.period, data[12:3]);
			compare_field("out_volume", e.volume, data[16:13]);
			compare_field("out_min_volume", e.min_volume, data[20:17]);
			compare_field("out_hold", e.hold, data[23:21]);
			compare_field("out_changed", e.changed, data[24]);
			compare_field("tdata padding", 0, data[31:25]);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	psg_scoreboard sb;
	bit            send_calm;
	bit            recv_calm;
	int unsigned   n_sent;
	int unsigned   n_results;

	dual_psg_register_write i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_word(input logic chip, input logic [7:0] wb);
		int unsigned gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= wb;
		s_tuser  <= chip;
		do @(posedge clk); while (!s_tready);
		sb.note_write(chip, wb);
		n_sent++;
		if (n_sent % 64 == 0)
			send_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_random();
		logic        chip;
		int unsigned pick;
		int unsigned n_data;
		chip = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick <= 3) begin
			// tone period: latch then one or two data words
			send_word(chip, LATCH_BIT | {1'b0, 2'($urandom_range(0, 2)), 1'b0,
				4'($urandom)});
			n_data = $urandom_range(1, 2);
			repeat (n_data) send_word(chip, 8'($urandom_range(0, 127)));
		end else if (pick <= 6) begin
			send_word(chip, LATCH_BIT | {1'b0, 2'($urandom), 1'b1, 4'($urandom)});
			if ($urandom_range(0, 3) == 0)
				send_word(chip, 8'($urandom_range(0, 127)));
		end else if (pick == 7) begin
			send_word(chip, LATCH_BIT | {1'b0, CH_NOISE, 1'b0, 4'($urandom)});
			send_word(chip, 8'($urandom_range(0, 127)));
		end else begin
			send_word(chip, 8'($urandom));
		end
	endtask

	initial begin
		sb        = new();
		send_calm = 1'b0;
		n_sent    = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: data at reset, period/volume extremes, noise masking,
		// data after a volume latch, both chips
		send_word(1'b0, 8'h00);
		send_word(1'b0, 8'h8F);
		send_word(1'b0, 8'h7F);
		send_word(1'b1, 8'hFF);
		send_word(1'b1, 8'hF0);
		send_word(1'b1, 8'h55);
		send_word(1'b1, 8'hE7);
		send_word(1'b1, 8'h7F);
		send_word(1'b1, 8'h00);
		send_word(1'b0, 8'hB5);
		send_word(1'b0, 8'hBF);
		send_word(1'b0, 8'hA0);
		send_word(1'b0, 8'h2A);
		send_word(1'b0, 8'hC3);
		send_word(1'b0, 8'h40);
		send_word(1'b0, 8'hDE);
		send_word(1'b1, 8'h80);
		send_word(1'b1, 8'h7F);
		send_word(1'b1, 8'h9A);
		send_word(1'b1, 8'hAF);
		send_word(1'b1, 8'h3F);
		send_word(1'b1, 8'hCF);
		send_word(1'b1, 8'h01);
		send_word(1'b1, 8'hD0);
		send_word(1'b0, 8'hF8);

		while (n_sent < N_RANDOM) send_random();
		s_tvalid <= 1'b0;

		while (sb.pending.size() > 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned stall;
		recv_calm = 1'b0;
		n_results = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = recv_calm ? 0 : $urandom_range(0, MAX_IDLE);
			// one long hold-off so the pipeline fills and backs up the input
			if (n_results == HOLD_AT)
				stall = LONG_HOLD;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_result(m_tdata, m_tuser);
			n_results++;
			if (n_results % 64 == 0)
				recv_calm = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
